>>> design/pwls_pkg.sv
// ----------------------------------------------------------------------------
// pwls_pkg: shared types and constants of the piecewise linear gray stretch.
// Holds the pixel and arithmetic widths, register indexes, reset values of
// the knee registers and the structs passed between pipeline sections.
// ----------------------------------------------------------------------------
package pwls_pkg;

	localparam int PIX_W     = 8;
	localparam int CNT_W     = 2;
	localparam int CFG_IDX_W = 3;

	// Rounded scale: numerator 2*dy*off + w, denominator 2*w.
	localparam int NUM_W = 2 * PIX_W + 1;
	localparam int DEN_W = PIX_W + 1;
	localparam int Q_W   = PIX_W;

	// Divider pipeline: quotient bits resolved per stage and stage count.
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = Q_W / DIV_BITS;

	localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

	// Register indexes; knee k uses CFG_KNEE_BASE + 2k (input) and + 2k + 1 (output).
	localparam logic [CFG_IDX_W-1:0] CFG_KNEE_COUNT = 3'd0;
	localparam int                   CFG_KNEE_BASE  = 1;

	localparam logic [CNT_W-1:0] KNEE_COUNT_RST = 2'd2;
	localparam logic [PIX_W-1:0] KNEE_IN_RST  [3] = '{8'd76, 8'd178, 8'd255};
	localparam logic [PIX_W-1:0] KNEE_OUT_RST [3] = '{8'd38, 8'd216, 8'd255};

	// Selected segment of one pixel.
	typedef struct packed {
		logic [PIX_W-1:0] off;
		logic [PIX_W-1:0] w;
		logic [PIX_W-1:0] dy;
		logic [PIX_W-1:0] y0;
		logic             neg;
	} seg_t;

	// Fields that ride alongside the divider.
	typedef struct packed {
		logic [PIX_W-1:0] y0;
		logic             neg;
	} side_t;

endpackage

>>> design/pwls_seg_select.sv
// ----------------------------------------------------------------------------
// pwls_seg_select: first pipeline stage of the gray stretch.
// Builds the monotone knee list and registers the segment that holds the
// pixel: offset into the segment, its width, rise and lower output level.
// ----------------------------------------------------------------------------
module pwls_seg_select import pwls_pkg::*; #(
	parameter int MAX_KNEES = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel,
	input  logic [CNT_W-1:0] knee_cnt,
	input  logic [PIX_W-1:0] knee_in  [MAX_KNEES],
	input  logic [PIX_W-1:0] knee_out [MAX_KNEES],
	output logic             out_valid,
	input  logic             out_ready,
	output seg_t             seg
);

	logic [PIX_W-1:0] bx [MAX_KNEES+1];
	logic [PIX_W-1:0] by [MAX_KNEES+1];
	logic [PIX_W-1:0] lx [MAX_KNEES+1];
	logic [PIX_W-1:0] ly [MAX_KNEES+1];
	seg_t             seg_nxt;
	seg_t             seg_s1;
	logic             v_s1;

	// Upper knees: inputs raised to a running maximum, unused knees at full scale.
	for (genvar k = 0; k < MAX_KNEES; k++) begin : g_knee
		logic [PIX_W-1:0] prev_x;
		if (k == 0) begin : g_first
			assign prev_x = '0;
		end else begin : g_rest
			assign prev_x = bx[k-1];
		end
		always_comb begin
			if (k < int'(knee_cnt)) begin
				bx[k] = (knee_in[k] < prev_x) ? prev_x : knee_in[k];
				by[k] = knee_out[k];
			end else begin
				bx[k] = FULL_SCALE;
				by[k] = FULL_SCALE;
			end
		end
	end
	assign bx[MAX_KNEES] = FULL_SCALE;
	assign by[MAX_KNEES] = FULL_SCALE;

	// Lower knee of each segment is the upper knee of the one before it.
	for (genvar k = 0; k <= MAX_KNEES; k++) begin : g_low
		if (k == 0) begin : g_origin
			assign lx[k] = '0;
			assign ly[k] = '0;
		end else begin : g_prev
			assign lx[k] = bx[k-1];
			assign ly[k] = by[k-1];
		end
	end

	// Pick the first segment whose upper knee lies above the pixel.
	always_comb begin
		logic found;
		found       = 1'b0;
		seg_nxt.off = '0;
		seg_nxt.w   = 8'd1;
		seg_nxt.dy  = '0;
		seg_nxt.y0  = FULL_SCALE;
		seg_nxt.neg = 1'b0;
		for (int k = 0; k <= MAX_KNEES; k++) begin
			if (!found && bx[k] > pixel) begin
				found       = 1'b1;
				seg_nxt.off = pixel - lx[k];
				seg_nxt.w   = bx[k] - lx[k];
				seg_nxt.y0  = ly[k];
				seg_nxt.neg = by[k] < ly[k];
				seg_nxt.dy  = (by[k] < ly[k]) ? (ly[k] - by[k]) : (by[k] - ly[k]);
			end
		end
	end

	assign in_ready = !v_s1 || out_ready;

	// Stage register: valid is control, the segment is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			seg_s1 <= seg_nxt;
		end
	end

	assign out_valid = v_s1;
	assign seg       = seg_s1;

endmodule

>>> design/pwls_divider.sv
// ----------------------------------------------------------------------------
// pwls_divider: pipelined restoring divider of the gray stretch.
// Resolves DIV_BITS quotient bits per stage over DIV_STAGES stages; the
// quotient is known to fit Q_W bits. Side fields travel with each word.
// ----------------------------------------------------------------------------
module pwls_divider import pwls_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  side_t            side_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [Q_W-1:0]   quot,
	output side_t            side_out
);

	logic             v_sd    [DIV_STAGES];
	logic [NUM_W-1:0] rem_sd  [DIV_STAGES];
	logic [DEN_W-1:0] den_sd  [DIV_STAGES];
	logic [Q_W-1:0]   q_sd    [DIV_STAGES];
	side_t            side_sd [DIV_STAGES];
	logic             adv     [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic             src_v;
		logic [NUM_W-1:0] src_rem;
		logic [DEN_W-1:0] src_den;
		logic [Q_W-1:0]   src_q;
		side_t            src_side;
		logic [NUM_W-1:0] nxt_rem;
		logic [Q_W-1:0]   nxt_q;

		if (j == 0) begin : g_head
			assign src_v    = in_valid;
			assign src_rem  = num;
			assign src_den  = den;
			assign src_q    = '0;
			assign src_side = side_in;
		end else begin : g_body
			assign src_v    = v_sd[j-1];
			assign src_rem  = rem_sd[j-1];
			assign src_den  = den_sd[j-1];
			assign src_q    = q_sd[j-1];
			assign src_side = side_sd[j-1];
		end

		// A stage moves when it is empty or the next one moves.
		if (j == DIV_STAGES - 1) begin : g_tail
			assign adv[j] = !v_sd[j] || out_ready;
		end else begin : g_mid
			assign adv[j] = !v_sd[j] || adv[j+1];
		end

		// Compare and subtract the shifted divisor, one quotient bit a step.
		always_comb begin
			logic [NUM_W-1:0] d;
			nxt_rem = src_rem;
			nxt_q   = src_q;
			for (int t = 0; t < DIV_BITS; t++) begin
				d = {{(NUM_W-DEN_W){1'b0}}, src_den} << (Q_W - 1 - j * DIV_BITS - t);
				if (nxt_rem >= d) begin
					nxt_rem = nxt_rem - d;
					nxt_q[Q_W-1-j*DIV_BITS-t] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[j] <= 1'b0;
			end else if (adv[j]) begin
				v_sd[j] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[j] && src_v) begin
				rem_sd[j]  <= nxt_rem;
				den_sd[j]  <= src_den;
				q_sd[j]    <= nxt_q;
				side_sd[j] <= src_side;
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_sd[DIV_STAGES-1];
	assign quot      = q_sd[DIV_STAGES-1];
	assign side_out  = side_sd[DIV_STAGES-1];

endmodule

>>> design/piecewise_linear_gray_stretch.sv
// ----------------------------------------------------------------------------
// piecewise_linear_gray_stretch: maps 8-bit gray pixels through a curve from
// (0,0) over up to three knee points to (255,255), rounding half away.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/in_stall/pixel_in; one word is taken at each edge
//   with in_valid high and in_stall low. Mapped pixels leave on
//   out_valid/out_stall/pixel_out under the same rule.
//   Knee registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high. Index 0 is the knee count, then input and output
//   level of each knee in turn. Write them only while no pixel is in flight.
//   The pipeline runs through segment select, multiply, four divider stages of two
//   quotient bits each, and the output add. One pixel per cycle is sustained
//   while the receiver does not stall.
//   Reset empties the pipeline and loads the default curve (two knees at
//   (76,38) and (178,216)). When the receiver stalls, each stage holds its
//   word and empty stages keep filling, so input is taken until all seven
//   stages are full; then in_stall follows out_stall.
// ----------------------------------------------------------------------------
module piecewise_linear_gray_stretch import pwls_pkg::*; #(
	parameter int MAX_KNEES = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     pixel_out
);

	logic [CNT_W-1:0] knee_count_q;
	logic [PIX_W-1:0] knee_in_q  [MAX_KNEES];
	logic [PIX_W-1:0] knee_out_q [MAX_KNEES];
	logic [CNT_W-1:0] knee_cnt;

	logic             seg_in_ready;
	logic             seg_valid;
	seg_t             seg;

	logic             v_s2;
	logic             adv_s2;
	logic [NUM_W-1:0] num_s2;
	logic [DEN_W-1:0] den_s2;
	side_t            side_s2;

	logic             div_in_ready;
	logic             div_valid;
	logic [Q_W-1:0]   div_quot;
	side_t            div_side;

	logic             v_q;
	logic             adv_out;
	logic [PIX_W-1:0] pix_q;

	// Configuration registers; unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knee_count_q <= KNEE_COUNT_RST;
			for (int k = 0; k < MAX_KNEES; k++) begin
				knee_in_q[k]  <= KNEE_IN_RST[k];
				knee_out_q[k] <= KNEE_OUT_RST[k];
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_KNEE_COUNT) begin
				knee_count_q <= cfg_data[CNT_W-1:0];
			end
			for (int k = 0; k < MAX_KNEES; k++) begin
				if (cfg_index == CFG_IDX_W'(CFG_KNEE_BASE + 2 * k)) begin
					knee_in_q[k] <= cfg_data;
				end
				if (cfg_index == CFG_IDX_W'(CFG_KNEE_BASE + 2 * k + 1)) begin
					knee_out_q[k] <= cfg_data;
				end
			end
		end
	end

	// A knee count above the supported number uses all supported knees.
	assign knee_cnt = (int'(knee_count_q) > MAX_KNEES) ? CNT_W'(MAX_KNEES) : knee_count_q;

	// Stage 1: segment select.
	pwls_seg_select #(
		.MAX_KNEES (MAX_KNEES)
	) u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (seg_in_ready),
		.pixel     (pixel_in),
		.knee_cnt  (knee_cnt),
		.knee_in   (knee_in_q),
		.knee_out  (knee_out_q),
		.out_valid (seg_valid),
		.out_ready (adv_s2),
		.seg       (seg)
	);

	assign in_stall = !seg_in_ready;

	// Stage 2: scaled offset with rounding term, 2*dy*off + w over 2*w.
	assign adv_s2 = !v_s2 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && seg_valid) begin
			num_s2       <= {(2 * PIX_W)'(seg.dy) * (2 * PIX_W)'(seg.off), 1'b0} +
				NUM_W'(seg.w);
			den_s2       <= {seg.w, 1'b0};
			side_s2.y0   <= seg.y0;
			side_s2.neg  <= seg.neg;
		end
	end

	// Stages 3 to 6: rounded quotient.
	pwls_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.num       (num_s2),
		.den       (den_s2),
		.side_in   (side_s2),
		.out_valid (div_valid),
		.out_ready (adv_out),
		.quot      (div_quot),
		.side_out  (div_side)
	);

	// Stage 7: lower knee level plus or minus the quotient, held for the receiver.
	assign adv_out = !v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv_out) begin
			v_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && div_valid) begin
			pix_q <= div_side.neg ? (div_side.y0 - div_quot) : (div_side.y0 + div_quot);
		end
	end

	assign out_valid = v_q;
	assign pixel_out = pix_q;

	// The selected segment always has positive width and holds the pixel.
	a_seg_width: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> (seg.w != '0) && (seg.off < seg.w))
		else $error("segment width zero or offset outside segment");

	// The quotient fits eight bits, so the divider never overflows.
	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (num_s2 < ({{(NUM_W-DEN_W){1'b0}}, den_s2} << Q_W)))
		else $error("numerator too large for an 8-bit quotient");

	// With the receiver taking words, no stage holds back the input.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while the output is free");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the piecewise linear gray stretch.
// Gray words are sent through the block while the curve registers are set
// between phases, and every mapped word is checked against a predicted value.
// A short directed part covers the default curve, the fixed endpoints,
// zero-width and falling segments, and decreasing knee inputs. It also covers
// knee counts with extra data bits and writes to the unused register index.
// Random curves with random pixels follow. Both sides idle at random, and one
// long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
	import pwls_pkg::*;

	localparam int MAX_KNEES      = 3;
	localparam int PIPE_LATENCY   = 7;
	localparam int SETTLE_CYCLES  = PIPE_LATENCY + 3;
	localparam int HOLD_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 17;

	// Index past the last knee register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	// One gray word in flight together with the level it should map to.
	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [PIX_W-1:0] mapped;
	} gray_map_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PIX_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel_in  = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PIX_W-1:0]     pixel_out;

	// Local copy of the curve registers, loaded with the reset curve.
	logic [CNT_W-1:0] knee_cnt  = 2'd2;
	logic [PIX_W-1:0] knee_x [3] = '{8'd76, 8'd178, 8'd255};
	logic [PIX_W-1:0] knee_y [3] = '{8'd38, 8'd216, 8'd255};

	gray_map_t pending_grays [$];
	int        errors      = 0;
	int        tx_busy_pct = 0;
	int        rx_busy_pct = 0;
	bit        hold_req    = 1'b0;

	piecewise_linear_gray_stretch #(.MAX_KNEES(MAX_KNEES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Maps one gray level through the current curve, rounding half away from zero.
	function automatic logic [PIX_W-1:0] stretch_gray(input logic [PIX_W-1:0] p);
		int n, k, x0, y0, x1, y1, w, off, q;
		n  = (knee_cnt > MAX_KNEES) ? MAX_KNEES : knee_cnt;
		x0 = 0;
		y0 = 0;
		for (k = 0; k <= n; k++) begin
			if (k < n) begin
				x1 = knee_x[k];
				y1 = knee_y[k];
				// Knee inputs never fall below the ones before them.
				if (x1 < x0)
					x1 = x0;
			end else begin
				x1 = FULL_SCALE;
				y1 = FULL_SCALE;
			end
			if (x1 > p) begin
				w   = x1 - x0;
				off = p - x0;
				if (y1 >= y0) begin
					q = (2 * (y1 - y0) * off + w) / (2 * w);
					return PIX_W'(y0 + q);
				end
				q = (2 * (y0 - y1) * off + w) / (2 * w);
				return PIX_W'(y0 - q);
			end
			x0 = x1;
			y0 = y1;
		end
		return FULL_SCALE;
	endfunction

	// Mirrors one register write into the local curve copy.
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [PIX_W-1:0] val);
		int rel;
		rel = int'(idx) - CFG_KNEE_BASE;
		if (idx == CFG_KNEE_COUNT) begin
			knee_cnt = val[CNT_W-1:0];
		end else if (idx != CFG_UNUSED) begin
			if (rel % 2 == 0)
				knee_x[rel / 2] = val;
			else
				knee_y[rel / 2] = val;
		end
	endfunction

	// Gap length for one side: mostly none or short, now and then long.
	function automatic int pick_gap(input int busy_pct);
		if ($urandom_range(99) >= busy_pct)
			return 0;
		if ($urandom_range(7) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	function automatic int pick_busy();
		case ($urandom_range(3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	// Knee input level, biased toward rising curves, repeats and the extremes.
	function automatic logic [PIX_W-1:0] pick_knee_in(input logic [PIX_W-1:0] prev);
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return PIX_W'($urandom_range(FULL_SCALE, prev));
		if (r < 60)
			return PIX_W'($urandom);
		if (r < 75)
			return prev;
		if (r < 85)
			return '0;
		if (r < 95)
			return FULL_SCALE;
		return prev + 1'b1;
	endfunction

	function automatic logic [PIX_W-1:0] pick_knee_out();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return PIX_W'($urandom);
		if (r < 85)
			return '0;
		return FULL_SCALE;
	endfunction

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin : receiver
		int stall_left;
		int g;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				g = pick_gap(rx_busy_pct);
				out_stall  <= (g > 0);
				stall_left = (g > 0) ? g - 1 : 0;
			end
		end
	end

	// Each mapped word taken by the receiver is compared with the oldest prediction.
	initial begin : result_check
		gray_map_t e;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_grays.size() == 0) begin
					$display("%0t: mapped word %0d arrived with none expected",
						$time, pixel_out);
					errors++;
				end else begin
					e = pending_grays.pop_front();
					if (pixel_out !== e.mapped) begin
						$display("%0t: pixel %0d expected %0d, actual %0d",
							$time, e.pixel, e.mapped, pixel_out);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: too many cycles without any word moving on any channel.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word moved for %0d cycles", $time, quiet);
		$display("tb_top NOT OK");
		$finish;
	end

	// Offers one gray word until taken, predicts its mapping, then idles at random.
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		gray_map_t e;
		int gap;
		pixel_in <= p;
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		e.pixel  = p;
		e.mapped = stretch_gray(p);
		pending_grays.push_back(e);
		gap = pick_gap(tx_busy_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			pixel_in <= PIX_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every predicted word has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_grays.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register; the caller lowers cfg_valid after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		apply_reg(idx, val);
	endtask

	// Loads a whole curve once the pipeline has drained.
	task automatic set_curve(input logic [CNT_W-1:0] cnt,
			input logic [PIX_W-1:0] x1, input logic [PIX_W-1:0] y1,
			input logic [PIX_W-1:0] x2, input logic [PIX_W-1:0] y2,
			input logic [PIX_W-1:0] x3, input logic [PIX_W-1:0] y3);
		logic [PIX_W-1:0] cnt_word;
		cnt_word = PIX_W'($urandom);
		cnt_word[CNT_W-1:0] = cnt;
		wait_idle();
		write_reg(CFG_KNEE_COUNT, cnt_word);
		write_reg(CFG_IDX_W'(CFG_KNEE_BASE),     x1);
		write_reg(CFG_IDX_W'(CFG_KNEE_BASE + 1), y1);
		write_reg(CFG_IDX_W'(CFG_KNEE_BASE + 2), x2);
		write_reg(CFG_IDX_W'(CFG_KNEE_BASE + 3), y2);
		write_reg(CFG_IDX_W'(CFG_KNEE_BASE + 4), x3);
		write_reg(CFG_IDX_W'(CFG_KNEE_BASE + 5), y3);
		cfg_valid <= 1'b0;
	endtask

	// Default curve after reset: endpoints, both sides of each knee, alternating bits.
	task automatic test_reset_curve();
		send_pixel(8'd0);
		send_pixel(8'd75);
		send_pixel(8'd76);
		send_pixel(8'd177);
		send_pixel(8'd178);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		send_pixel(8'd255);
	endtask

	// Hand-picked curves for the corner cases of segment selection.
	task automatic test_corner_curves();
		// No knees: the straight line from black to white.
		set_curve(2'd0, 8'd10, 8'd200, 8'd20, 8'd30, 8'd40, 8'd50);
		send_pixel(8'd0);
		send_pixel(8'd128);
		send_pixel(8'd255);
		// All knees at zero: only zero-width segments before the last one.
		set_curve(2'd3, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd100);
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'd254);
		// Decreasing knee inputs are lifted to the running maximum.
		set_curve(2'd3, 8'd200, 8'd250, 8'd100, 8'd10, 8'd50, 8'd128);
		send_pixel(8'd150);
		send_pixel(8'd199);
		send_pixel(8'd200);
		send_pixel(8'd201);
		// Steep rise, long falling segment, then back up to white.
		set_curve(2'd2, 8'd1, 8'd255, 8'd254, 8'd0, 8'd7, 8'd7);
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'd127);
		send_pixel(8'd253);
		send_pixel(8'd254);
		// The unused index must leave the curve alone.
		wait_idle();
		write_reg(CFG_UNUSED, 8'hFF);
		cfg_valid <= 1'b0;
		send_pixel(8'd100);
	endtask

	// Long receiver hold-off while words keep coming, then a full drain.
	task automatic test_backpressure();
		int n;
		tx_busy_pct = 0;
		rx_busy_pct = 0;
		hold_req    = 1'b1;
		for (n = 0; n < 40; n++)
			send_pixel(PIX_W'($urandom));
		wait_idle();
		rx_busy_pct = 40;
		for (n = 0; n < 60; n++)
			send_pixel(PIX_W'($urandom));
		wait_idle();
	endtask

	// Random curves, each followed by a burst of random and near-knee pixels.
	task automatic test_random_curves();
		int phase, n, items;
		logic [PIX_W-1:0] x1, x2, x3;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			x1 = pick_knee_in('0);
			x2 = pick_knee_in(x1);
			x3 = pick_knee_in(x2);
			set_curve(CNT_W'($urandom_range(3)), x1, pick_knee_out(),
				x2, pick_knee_out(), x3, pick_knee_out());
			tx_busy_pct = (phase == 0) ? 0 : pick_busy();
			rx_busy_pct = (phase == 0) ? 0 : pick_busy();
			items = $urandom_range(130, 90);
			for (n = 0; n < items; n++) begin
				if ($urandom_range(3) == 0)
					send_pixel(PIX_W'(int'(knee_x[$urandom_range(2)]) +
						$urandom_range(2) - 1));
				else
					send_pixel(PIX_W'($urandom));
			end
		end
	endtask

	initial begin : main
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_curve();
		test_corner_curves();
		test_backpressure();
		test_random_curves();
		wait_idle();
		if (pending_grays.size() != 0)
			$display("%0t: %0d mapped words never arrived", $time, pending_grays.size());
		if (errors == 0 && pending_grays.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
